@@ rtl/meu_pkg.sv @@
// Package: shared types, constants and commands for the modular exponent unit
`timescale 1ns / 1ps
`default_nettype none
package meu_pkg;
  localparam int unsigned ModW = 32;
  localparam int unsigned OpW = 2;
  localparam int unsigned ValW = 64;
  localparam int unsigned CntW = 7;
  localparam logic [ModW-1:0] ModReset = 32'd1000000007;

  typedef enum logic [OpW-1:0] {
    OP_POW = 2'd0,
    OP_INV = 2'd1,
    OP_DIV = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DSEL_BASE = 3'd0,
    DSEL_DEN = 3'd1,
    DSEL_ACC = 3'd2,
    DSEL_SQR = 3'd3,
    DSEL_FIN = 3'd4
  } dsel_t;

  typedef struct packed {
    logic  load;
    logic  red_start;
    logic  red_neg;
    dsel_t sel;
    logic  use_fermat;
    logic  set_acc_one;
    logic  set_zero;
  } meu_cmd_t;

  typedef struct packed {
    logic red_busy;
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
  } meu_sts_t;
endpackage
`default_nettype wire

@@ rtl/meu_if.sv @@
// Interfaces: valid/ready channels for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface meu_req_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [63:0] base_value;
  logic [63:0] power_exponent;
  logic signed [63:0] denominator_value;
  modport source (output valid, op, base_value, power_exponent, denominator_value, input ready);
  modport sink (input valid, op, base_value, power_exponent, denominator_value, output ready);
endinterface

interface meu_res_if;
  logic valid;
  logic ready;
  logic [31:0] residue;
  modport source (output valid, residue, input ready);
  modport sink (input valid, residue, output ready);
endinterface
`default_nettype wire

@@ rtl/meu_reducer.sv @@
// Reducer: restoring remainder of a 64-bit value by the 32-bit modulus, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module meu_reducer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [meu_pkg::ValW-1:0]  dividend,
  input  wire logic [meu_pkg::ModW-1:0]  modulus,
  output logic                           busy,
  output logic [meu_pkg::ModW-1:0]       remainder
);
  import meu_pkg::*;

  logic [ValW-1:0] shf_r, shf_nxt;
  logic [ModW:0] rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [ModW:0] trial;
  logic [ModW+1:0] diff;

  always_comb begin
    shf_nxt = shf_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[ModW-1:0], shf_r[ValW-1]};
    diff = {1'b0, trial} - {2'b00, modulus};
    if (start) begin
      shf_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      shf_nxt = {shf_r[ValW-2:0], 1'b0};
      rem_nxt = diff[ModW+1] ? trial : diff[ModW:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(ValW - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign remainder = rem_r[ModW-1:0];
endmodule
`default_nettype wire

@@ rtl/meu_datapath.sv @@
// Datapath: operand registers, multiplier and shared reducer
`timescale 1ns / 1ps
`default_nettype none
module meu_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire meu_pkg::meu_cmd_t         cmd,
  input  wire logic [63:0]               in_base,
  input  wire logic [63:0]               in_exp,
  input  wire logic [63:0]               in_den,
  input  wire logic [meu_pkg::ModW-1:0]  modulus,
  output meu_pkg::meu_sts_t              sts,
  output logic [meu_pkg::ModW-1:0]       residue
);
  import meu_pkg::*;

  logic [ValW-1:0] base_raw_r, den_raw_r, exp_r, exp_nxt;
  logic [ModW-1:0] b_r, acc_r, num_r, res_r;
  logic [ModW-1:0] b_nxt, acc_nxt, num_nxt, res_nxt;
  logic [ValW-1:0] prod, red_in, negv;
  logic [ModW-1:0] rem, rem_fix;
  logic red_busy;
  logic [ModW-1:0] mA, mB;
  logic neg_r;
  logic [ModW-1:0] m_r;

  always_comb begin
    mA = acc_r;
    mB = b_r;
    case (cmd.sel)
      DSEL_SQR: mA = b_r;
      DSEL_FIN: begin
        mA = num_r;
        mB = acc_r;
      end
      default: mA = acc_r;
    endcase
    prod = {32'd0, mA} * {32'd0, mB};
    red_in = prod;
    case (cmd.sel)
      DSEL_BASE: red_in = base_raw_r[ValW-1] ? (64'd0 - base_raw_r) : base_raw_r;
      DSEL_DEN: red_in = den_raw_r[ValW-1] ? (64'd0 - den_raw_r) : den_raw_r;
      default: red_in = prod;
    endcase
    negv = {32'd0, m_r} - {32'd0, rem};
    rem_fix = (neg_r && rem != '0) ? negv[ModW-1:0] : rem;
  end

  meu_reducer u_red (
    .clk(clk), .rst_n(rst_n), .start(cmd.red_start), .dividend(red_in),
    .modulus(m_r), .busy(red_busy), .remainder(rem)
  );

  always_comb begin
    exp_nxt = exp_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    num_nxt = num_r;
    res_nxt = res_r;
    if (cmd.load) begin
      exp_nxt = in_exp;
    end
    if (cmd.use_fermat) exp_nxt = {32'd0, m_r} - 64'd2;
    if (cmd.set_acc_one) acc_nxt = 32'd1;
    if (cmd.set_zero) res_nxt = '0;
    if (cmd.red_neg) begin
      case (cmd.sel)
        DSEL_BASE: begin
          b_nxt = rem_fix;
          num_nxt = rem_fix;
        end
        DSEL_DEN: b_nxt = rem_fix;
        DSEL_ACC: acc_nxt = rem;
        DSEL_SQR: begin
          b_nxt = rem;
          exp_nxt = {1'b0, exp_r[ValW-1:1]};
        end
        DSEL_FIN: res_nxt = rem;
        default: res_nxt = res_r;
      endcase
    end
    if (cmd.set_acc_one && cmd.sel == DSEL_FIN) res_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r <= 1'b0;
    end else if (cmd.red_start) begin
      neg_r <= (cmd.sel == DSEL_BASE) ? base_raw_r[ValW-1]
             : (cmd.sel == DSEL_DEN) ? den_raw_r[ValW-1] : 1'b0;
    end
    if (cmd.load) begin
      base_raw_r <= in_base;
      den_raw_r <= in_den;
      m_r <= modulus;
    end
    exp_r <= exp_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    res_r <= res_nxt;
  end

  assign sts.red_busy = red_busy;
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb = exp_r[0];
  assign sts.mod_zero = (m_r == '0);
  assign residue = res_r;
endmodule
`default_nettype wire

@@ rtl/meu_ctrl.sv @@
// Controller: sequences reduction, square-and-multiply and result handshake
`timescale 1ns / 1ps
`default_nettype none
module meu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_op,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire meu_pkg::meu_sts_t   sts,
  output meu_pkg::meu_cmd_t        cmd
);
  import meu_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RBASE = 10'b0000000010,
    S_WBASE = 10'b0000000100,
    S_RDEN  = 10'b0000001000,
    S_WDEN  = 10'b0000010000,
    S_LOOP  = 10'b0000100000,
    S_WMUL  = 10'b0001000000,
    S_WSQR  = 10'b0010000000,
    S_WFIN  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic first_r, first_nxt;
  logic vld_r, vld_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    first_nxt = first_r;
    vld_nxt = vld_r;
    cmd = '0;
    cmd.sel = DSEL_ACC;
    if (vld_r && out_ready) vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (!vld_r || out_ready)) begin
          cmd.load = 1'b1;
          op_nxt = op_t'(in_op);
          state_nxt = S_RBASE;
        end
      end
      S_RBASE: begin
        if (sts.mod_zero || op_r == OP_NONE) begin
          cmd.set_zero = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.sel = DSEL_BASE;
          cmd.red_start = 1'b1;
          state_nxt = S_WBASE;
        end
      end
      S_WBASE: begin
        cmd.sel = DSEL_BASE;
        if (!sts.red_busy) begin
          cmd.red_neg = 1'b1;
          cmd.set_acc_one = 1'b1;
          cmd.use_fermat = (op_r != OP_POW);
          state_nxt = (op_r == OP_DIV) ? S_RDEN : S_LOOP;
        end
      end
      S_RDEN: begin
        cmd.sel = DSEL_DEN;
        cmd.red_start = 1'b1;
        state_nxt = S_WDEN;
      end
      S_WDEN: begin
        cmd.sel = DSEL_DEN;
        if (!sts.red_busy) begin
          cmd.red_neg = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.exp_zero) begin
          if (op_r == OP_DIV) begin
            cmd.sel = DSEL_FIN;
            cmd.red_start = 1'b1;
            state_nxt = S_WFIN;
          end else begin
            cmd.sel = DSEL_FIN;
            cmd.set_acc_one = 1'b0;
            state_nxt = S_DONE;
            first_nxt = 1'b1;
          end
        end else if (sts.exp_lsb) begin
          cmd.sel = DSEL_ACC;
          cmd.red_start = 1'b1;
          state_nxt = S_WMUL;
        end else begin
          cmd.sel = DSEL_SQR;
          cmd.red_start = 1'b1;
          state_nxt = S_WSQR;
        end
      end
      S_WMUL: begin
        cmd.sel = DSEL_ACC;
        if (!sts.red_busy) begin
          cmd.red_neg = 1'b1;
          state_nxt = S_WSQR;
          cmd.red_start = 1'b0;
        end
      end
      S_WSQR: begin
        cmd.sel = DSEL_SQR;
        if (first_r) begin
          cmd.red_start = 1'b1;
          first_nxt = 1'b0;
        end else if (!sts.red_busy) begin
          cmd.red_neg = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_WFIN: begin
        cmd.sel = DSEL_FIN;
        if (!sts.red_busy) begin
          cmd.red_neg = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (first_r) begin
          cmd.sel = DSEL_FIN;
          cmd.set_acc_one = 1'b1;
          first_nxt = 1'b0;
        end
        vld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_WMUL && !sts.red_busy) first_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= 1'b0;
      first_r <= 1'b0;
      op_r <= OP_POW;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
      first_r <= first_nxt;
      op_r <= op_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE) && (!vld_r || out_ready);
  assign out_valid = vld_r;
endmodule
`default_nettype wire

@@ rtl/modular_exponent_unit.sv @@
// Top level: modular exponent unit
//  channel  dir  payload
//  in_      in   op, base_value, power_exponent, denominator_value
//  out_     out  residue
//  cfg_     in   modulus write
// One request at a time; a shared bit-serial reducer sets the pace.
// Up to 129 reductions per request.
// Synchronous active-low reset; modulus resets to 1000000007.
// A finished result is held until taken; the next request is taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module modular_exponent_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  meu_req_if.sink                        in_req,
  meu_res_if.source                      out_res,
  input  wire logic                      cfg_we,
  input  wire logic [meu_pkg::ModW-1:0]  cfg_wdata
);
  import meu_pkg::*;

  logic [ModW-1:0] mod_r;
  meu_cmd_t cmd;
  meu_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= ModReset;
    else if (cfg_we) mod_r <= cfg_wdata;
  end

  meu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_op(in_req.op),
    .in_ready(in_req.ready), .out_valid(out_res.valid), .out_ready(out_res.ready),
    .sts(sts), .cmd(cmd)
  );

  meu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_base(in_req.base_value), .in_exp(in_req.power_exponent),
    .in_den(in_req.denominator_value), .modulus(mod_r), .sts(sts),
    .residue(out_res.residue)
  );
endmodule
`default_nettype wire
